// ===== rtl/cylinder_obstacle_cost_defines.svh =====
// ----------------------------------------------------------------------------
// cylinder obstacle cost assertion macros
// shared concurrent assertion helpers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef CYLINDER_OBSTACLE_COST_DEFINES_SVH
`define CYLINDER_OBSTACLE_COST_DEFINES_SVH
`ifndef SYNTHESIS
`define COC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("coc assertion failed");
`define COC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("coc implication failed");
`else
`define COC_ASSERT(lbl, prop)
`define COC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== rtl/coc_pkg.sv =====
// ----------------------------------------------------------------------------
// coc_pkg
// shared types and constants of the cylinder obstacle cost block
// ----------------------------------------------------------------------------
package coc_pkg;

  localparam int MAX_CYL = 16;
  localparam int IDX_W   = $clog2(MAX_CYL);
  localparam int CNT_W   = 5;
  localparam int COST_W  = 40;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] CFG_COUNT   = 3'd0;
  localparam logic [2:0] CFG_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_HIT     = 3'd2;
  localparam logic [2:0] CFG_WARN    = 3'd3;
  localparam logic [2:0] CFG_LIFT    = 3'd4;
  localparam logic [2:0] CFG_HITCOST = 3'd5;
  localparam logic [2:0] CFG_WGAIN   = 3'd6;
  localparam logic [2:0] CFG_LGAIN   = 3'd7;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [22:0]        r;
    logic signed [23:0] bz;
    logic signed [23:0] tz;
  } cyl_t;

  localparam int ENTRY_W = $bits(cyl_t);

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
  } point_t;

  typedef struct packed {
    logic             valid;
    point_t           pt;
  } query_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    cyl_t             data;
  } tbl_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [19:0]      height_margin;
    logic [19:0]      hit_margin;
    logic [19:0]      warning_margin;
    logic [19:0]      lift_margin;
    logic [31:0]      hit_cost;
    logic [19:0]      warning_gain;
    logic [15:0]      lift_gain;
  } cfg_t;

endpackage

// ===== rtl/coc_ram.sv =====
// ----------------------------------------------------------------------------
// coc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module coc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/coc_front.sv =====
// ----------------------------------------------------------------------------
// coc_front
// accepts requests, loads table entries, queues query points
// ----------------------------------------------------------------------------
`include "cylinder_obstacle_cost_defines.svh"

module coc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic [coc_pkg::IDX_W-1:0] entry_index,
  input  logic signed [23:0]        center_x,
  input  logic signed [23:0]        center_y,
  input  logic [22:0]               radius,
  input  logic signed [23:0]        bottom_z,
  input  logic signed [23:0]        top_z,
  input  logic signed [23:0]        point_x,
  input  logic signed [23:0]        point_y,
  input  logic signed [23:0]        point_z,
  input  logic                      back_busy,
  input  logic                      q_pop,
  output coc_pkg::query_t           q_head,
  output coc_pkg::tbl_wr_t          tbl_wr
);

  coc_pkg::point_t q_mem [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      q_count;
  logic            push;
  logic            fire;

  // table writes wait until no query is pending so each query sees a fixed table
  assign in_ready = (opcode == coc_pkg::OP_QUERY) ? (q_count != 2'd2)
                                                  : (q_count == 2'd0 && !back_busy);
  assign fire = in_valid && in_ready;
  assign push = fire && (opcode == coc_pkg::OP_QUERY);

  assign tbl_wr.en      = fire && (opcode == coc_pkg::OP_WRITE);
  assign tbl_wr.addr    = entry_index;
  assign tbl_wr.data.cx = center_x;
  assign tbl_wr.data.cy = center_y;
  assign tbl_wr.data.r  = radius;
  assign tbl_wr.data.bz = bottom_z;
  assign tbl_wr.data.tz = top_z;

  assign q_head.valid = (q_count != 2'd0);
  assign q_head.pt    = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= '{px: point_x, py: point_y, pz: point_z};
    end
    if (rst) begin
      wptr    <= 1'b0;
      rptr    <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `COC_ASSERT(a_q_bound, q_count != 2'd3)
  `COC_ASSERT_IMPL(a_pop_nonempty, q_pop, q_count != 2'd0)

endmodule

// ===== rtl/coc_back.sv =====
// ----------------------------------------------------------------------------
// coc_back
// walks the active entries for one query and accumulates the cost
// ----------------------------------------------------------------------------
`include "cylinder_obstacle_cost_defines.svh"

module coc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  coc_pkg::cfg_t              cfg,
  input  coc_pkg::query_t            q_head,
  output logic                       q_pop,
  output logic                       busy,
  output logic [coc_pkg::IDX_W-1:0]  rd_addr,
  input  coc_pkg::cyl_t              rd_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [coc_pkg::COST_W-1:0] total_cost,
  output logic                       cost_saturated
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_ROOT = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_EX   = 4'd7;
  localparam logic [3:0] S_WQ   = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_LIFT = 4'd10;
  localparam logic [3:0] S_LADD = 4'd11;
  localparam logic [3:0] S_ACC  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0]                 state;
  logic [coc_pkg::CNT_W-1:0]  idx;
  logic [coc_pkg::CNT_W-1:0]  n_lim;
  logic [coc_pkg::CNT_W-1:0]  n_cfg;
  coc_pkg::point_t            pt;
  coc_pkg::cyl_t              cyl;
  logic [24:0]                adx;
  logic [24:0]                ady;
  logic [49:0]                sqx;
  logic [49:0]                sqy;
  logic [49:0]                rem;
  logic [49:0]                root;
  logic [49:0]                sbit;
  logic [49:0]                trial;
  logic [23:0]                ex;
  logic [47:0]                exsq;
  logic [43:0]                p1;
  logic [43:0]                p2;
  logic [41:0]                p3;
  logic                       lift_on;
  logic [45:0]                term;
  logic [coc_pkg::COST_W-1:0] sum;
  logic                       sat;
  logic [46:0]                acc;
  logic signed [25:0]         pz_e;
  logic signed [25:0]         lo;
  logic signed [25:0]         hi;
  logic signed [25:0]         target;
  logic signed [25:0]         shortfall;
  logic signed [24:0]         dx;
  logic signed [24:0]         dy;
  logic [24:0]                hdist;
  logic [23:0]                rd_r;
  logic [23:0]                rw_r;

  assign n_cfg = (cfg.count > coc_pkg::CNT_W'(coc_pkg::MAX_CYL))
               ? coc_pkg::CNT_W'(coc_pkg::MAX_CYL) : cfg.count;
  assign rd_addr = idx[coc_pkg::IDX_W-1:0];
  assign busy    = (state != S_IDLE);
  assign q_pop   = (state == S_IDLE) && q_head.valid;

  assign pz_e      = 26'(pt.pz);
  assign lo        = 26'(rd_data.bz) - $signed({6'd0, cfg.height_margin});
  assign hi        = 26'(rd_data.tz) + $signed({6'd0, cfg.height_margin});
  assign target    = 26'(cyl.tz) + $signed({6'd0, cfg.lift_margin});
  assign shortfall = target - pz_e;
  assign dx        = 25'(pt.px) - 25'(rd_data.cx);
  assign dy        = 25'(pt.py) - 25'(rd_data.cy);
  assign trial     = root + sbit;
  assign hdist     = root[24:0];
  assign rd_r      = {1'b0, cyl.r} + {4'd0, cfg.hit_margin};
  assign rw_r      = {1'b0, cyl.r} + {4'd0, cfg.warning_margin};
  assign acc       = {7'd0, sum} + {1'b0, term};

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pt <= q_head.pt;
      end
      S_CHK: begin
        cyl <= rd_data;
        adx <= dx[24] ? 25'(-dx) : 25'(dx);
        ady <= dy[24] ? 25'(-dy) : 25'(dy);
        term <= '0;
      end
      S_SQ: begin
        sqx <= adx * adx;
        sqy <= ady * ady;
      end
      S_SUM: begin
        rem  <= sqx + sqy;
        root <= '0;
        sbit <= 50'd1 << 48;
      end
      S_ROOT: begin
        // one result bit per cycle, restoring form
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      S_CMP: begin
        if ({1'b0, hdist} < {1'b0, rd_r}) begin
          term <= 46'(cfg.hit_cost);
        end else if ({1'b0, hdist} < {1'b0, rw_r}) begin
          ex <= 24'({1'b0, rw_r} - {1'b0, hdist});
        end
      end
      S_EX: begin
        exsq <= ex * ex;
      end
      S_WQ: begin
        p1 <= cfg.warning_gain * exsq[47:24];
      end
      S_WR: begin
        p2   <= cfg.warning_gain * exsq[23:0];
        term <= {2'd0, p1};
      end
      S_LIFT: begin
        lift_on <= (pz_e < target);
        // shortfall is only used when positive
        p3      <= cfg.lift_gain * shortfall[24:0];
        term    <= term + {26'd0, p2[43:24]};
      end
      S_LADD: begin
        if (lift_on) begin
          term <= term + {12'd0, p3[41:8]};
        end
      end
      default: begin
      end
    endcase
    if (state == S_DONE && (!out_valid || out_ready)) begin
      total_cost     <= sum;
      cost_saturated <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      n_lim     <= '0;
      sum       <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_head.valid) begin
            idx   <= '0;
            n_lim <= n_cfg;
            sum   <= '0;
            sat   <= 1'b0;
            state <= (n_cfg == '0) ? S_DONE : S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (pz_e < lo || pz_e > hi) begin
            state <= S_ACC;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_SUM;
        S_SUM: state <= S_ROOT;
        S_ROOT: begin
          if (sbit[0]) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if ({1'b0, hdist} >= {1'b0, rd_r} && {1'b0, hdist} < {1'b0, rw_r}) begin
            state <= S_EX;
          end else begin
            state <= S_ACC;
          end
        end
        S_EX: state <= S_WQ;
        S_WQ: state <= S_WR;
        S_WR: state <= S_LIFT;
        S_LIFT: state <= S_LADD;
        S_LADD: state <= S_ACC;
        S_ACC: begin
          if (acc > {7'd0, coc_pkg::COST_MAX}) begin
            sum <= coc_pkg::COST_MAX;
            sat <= 1'b1;
          end else begin
            sum <= acc[coc_pkg::COST_W-1:0];
          end
          idx <= idx + 1'b1;
          state <= (idx + 1'b1 == n_lim) ? S_DONE : S_RD;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `COC_ASSERT(a_bit_onehot, (state != S_ROOT) || $onehot(sbit))
  `COC_ASSERT_IMPL(a_idx_range, state != S_IDLE && state != S_DONE, idx < n_lim)
  `COC_ASSERT_IMPL(a_sat_max, out_valid && cost_saturated, total_cost == coc_pkg::COST_MAX)

endmodule

// ===== rtl/cylinder_obstacle_cost.sv =====
// ----------------------------------------------------------------------------
// cylinder_obstacle_cost
// obstacle cost of a 3-d point against a table of vertical cylinders
// ----------------------------------------------------------------------------
// A write request (opcode 0) loads one of 16 table entries and gives no result;
// a query request (opcode 1) gives one result, the saturating Q8 cost summed over
// the first cylinder_count entries (at most 16). Entries are handled one at a time by a
// single sequencer: an entry outside the height span is skipped after its read and
// height check, one in range also passes the squares, the bit-serial square root and
// the radius compare, and one in the warning band adds the band and lift terms. Up to
// two queries wait in a queue ahead of the sequencer; a write request is held off
// until all queued queries have finished reading the table. Entries must be written
// before a query reads them.
module cylinder_obstacle_cost (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       opcode,
  input  logic [3:0]                 entry_index,
  input  logic signed [23:0]         center_x,
  input  logic signed [23:0]         center_y,
  input  logic [22:0]                radius,
  input  logic signed [23:0]         bottom_z,
  input  logic signed [23:0]         top_z,
  input  logic signed [23:0]         point_x,
  input  logic signed [23:0]         point_y,
  input  logic signed [23:0]         point_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [39:0]                total_cost,
  output logic                       cost_saturated
);

  coc_pkg::cfg_t                    cfg;
  coc_pkg::query_t                  q_head;
  coc_pkg::tbl_wr_t                 tbl_wr;
  coc_pkg::cyl_t                    rd_data;
  logic [coc_pkg::ENTRY_W-1:0]      rd_raw;
  logic [coc_pkg::IDX_W-1:0]        rd_addr;
  logic                             q_pop;
  logic                             back_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count          <= '0;
      cfg.height_margin  <= 20'd3277;
      cfg.hit_margin     <= 20'd7864;
      cfg.warning_margin <= 20'd19661;
      cfg.lift_margin    <= 20'd9830;
      cfg.hit_cost       <= 32'd128000000;
      cfg.warning_gain   <= 20'd200000;
      cfg.lift_gain      <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        coc_pkg::CFG_COUNT:   cfg.count          <= cfg_data[coc_pkg::CNT_W-1:0];
        coc_pkg::CFG_HEIGHT:  cfg.height_margin  <= cfg_data[19:0];
        coc_pkg::CFG_HIT:     cfg.hit_margin     <= cfg_data[19:0];
        coc_pkg::CFG_WARN:    cfg.warning_margin <= cfg_data[19:0];
        coc_pkg::CFG_LIFT:    cfg.lift_margin    <= cfg_data[19:0];
        coc_pkg::CFG_HITCOST: cfg.hit_cost       <= cfg_data;
        coc_pkg::CFG_WGAIN:   cfg.warning_gain   <= cfg_data[19:0];
        coc_pkg::CFG_LGAIN:   cfg.lift_gain      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  coc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .entry_index (entry_index),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .bottom_z    (bottom_z),
    .top_z       (top_z),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .back_busy   (back_busy),
    .q_pop       (q_pop),
    .q_head      (q_head),
    .tbl_wr      (tbl_wr)
  );

  coc_ram #(
    .WIDTH (coc_pkg::ENTRY_W),
    .DEPTH (coc_pkg::MAX_CYL)
  ) u_table (
    .clk   (clk),
    .we    (tbl_wr.en),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  assign rd_data = rd_raw;

  coc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .busy           (back_busy),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .total_cost     (total_cost),
    .cost_saturated (cost_saturated)
  );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// cylinder obstacle cost testbench
// loads cylinder tables, queries points against a local cost predictor and
// compares every returned cost in order, under random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import coc_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [39:0] cost;
    logic        sat;
  } cost_t;

  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [23:0] cx, cy;
    logic [22:0] r;
    logic [23:0] bz, tz, px, py, pz;
    logic        chk;
    cost_t       want;
  } stim_t;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic opcode;
  logic [3:0] entry_index;
  logic signed [23:0] center_x, center_y, bottom_z, top_z, point_x, point_y, point_z;
  logic [22:0] radius;
  logic [39:0] total_cost;
  logic cost_saturated;

  cylinder_obstacle_cost u_dut (.*);

  // predictor state
  cyl_t        table_q[MAX_CYL];
  logic [4:0]  m_count;
  logic [19:0] m_height, m_hit, m_warn, m_lift, m_wgain;
  logic [31:0] m_hitcost;
  logic [15:0] m_lgain;
  bit          written[MAX_CYL];

  cost_t pending_costs[$];
  int    mismatches;
  int    idle_cycles;
  bit    no_stall;
  bit    timed_out;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic cost_t point_cost(logic signed [23:0] px, logic signed [23:0] py,
                                       logic signed [23:0] pz);
    cost_t res;
    longint unsigned sum, d, rd, rw, term, ex, sq, adx, ady;
    longint dx, dy, tgt;
    int n;
    sum = 0;
    res.sat = 0;
    n = (m_count > MAX_CYL) ? MAX_CYL : m_count;
    for (int i = 0; i < n; i++) begin
      if (longint'(pz) < longint'(table_q[i].bz) - longint'(m_height)) continue;
      if (longint'(pz) > longint'(table_q[i].tz) + longint'(m_height)) continue;
      dx = longint'(px) - longint'(table_q[i].cx);
      dy = longint'(py) - longint'(table_q[i].cy);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      d = root64(adx * adx + ady * ady);
      rd = longint'(table_q[i].r) + m_hit;
      rw = longint'(table_q[i].r) + m_warn;
      term = 0;
      if (d < rd) begin
        term = m_hitcost;
      end else if (d < rw) begin
        ex = rw - d;
        sq = ex * ex;
        term = longint'(m_wgain) * (sq >> 24) + ((longint'(m_wgain) * (sq & 24'hFFFFFF)) >> 24);
        tgt = longint'(table_q[i].tz) + longint'(m_lift);
        if (longint'(pz) < tgt) term += (longint'(m_lgain) * (tgt - longint'(pz))) >> 8;
      end
      sum += term;
      if (sum > COST_MAX) begin
        sum = COST_MAX;
        res.sat = 1;
      end
    end
    res.cost = sum[39:0];
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_COUNT:   m_count = val[4:0];
      CFG_HEIGHT:  m_height = val[19:0];
      CFG_HIT:     m_hit = val[19:0];
      CFG_WARN:    m_warn = val[19:0];
      CFG_LIFT:    m_lift = val[19:0];
      CFG_HITCOST: m_hitcost = val;
      CFG_WGAIN:   m_wgain = val[19:0];
      default:     m_lgain = val[15:0];
    endcase
  endtask

  // wait for all results, then let a full query's worth of cycles drain
  task automatic drain();
    while (pending_costs.size() != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  task automatic send(stim_t s);
    if (!no_stall && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clk);
    in_valid = 1;
    opcode <= s.op;
    entry_index <= s.idx;
    center_x <= s.cx;
    center_y <= s.cy;
    radius <= s.r;
    bottom_z <= s.bz;
    top_z <= s.tz;
    point_x <= s.px;
    point_y <= s.py;
    point_z <= s.pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (s.op == OP_WRITE) begin
      table_q[s.idx] = {s.cx, s.cy, s.r, s.bz, s.tz};
      written[s.idx] = 1;
    end else begin
      pending_costs.insert(pending_costs.size(),
                           s.chk ? s.want : point_cost(s.px, s.py, s.pz));
    end
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic stim_t cyl_item(int idx, int cx, int cy, int r, int bz, int tz);
    stim_t s;
    s = '{default: '0};
    s.op = OP_WRITE;
    s.idx = 4'(idx);
    s.cx = 24'(cx); s.cy = 24'(cy); s.r = 23'(r); s.bz = 24'(bz); s.tz = 24'(tz);
    s.px = 24'($urandom); s.py = 24'($urandom); s.pz = 24'($urandom);
    return s;
  endfunction

  function automatic stim_t query_item(int px, int py, int pz);
    stim_t s;
    s = '{default: '0};
    s.op = OP_QUERY;
    s.idx = 4'($urandom);
    s.cx = 24'($urandom); s.cy = 24'($urandom); s.r = 23'($urandom);
    s.bz = 24'($urandom); s.tz = 24'($urandom);
    s.px = 24'(px); s.py = 24'(py); s.pz = 24'(pz);
    return s;
  endfunction

  function automatic stim_t rand_cyl(int idx);
    int r;
    r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8388607) : $urandom_range(0, 300000);
    if ($urandom_range(0, 9) == 0)
      return cyl_item(idx, $urandom, $urandom, r, $urandom, $urandom);
    return cyl_item(idx, $urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
                    r, $urandom_range(0, 200000) - 150000, $urandom_range(0, 200000));
  endfunction

  function automatic stim_t rand_query();
    if ($urandom_range(0, 9) == 0) return query_item($urandom, $urandom, $urandom);
    return query_item($urandom_range(0, 800000) - 400000, $urandom_range(0, 800000) - 400000,
                      $urandom_range(0, 400000) - 200000);
  endfunction

  // result side
  always @(posedge clk) begin
    cost_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_costs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result cost=%0d sat=%0b", total_cost, cost_saturated);
      end else begin
        want = pending_costs.pop_front();
        if (want.cost !== total_cost || want.sat !== cost_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cost mismatch: want %0d/%0b got %0d/%0b", want.cost, want.sat,
                     total_cost, cost_saturated);
        end
      end
    end
  end

  initial begin
    int burst;
    out_ready = 1;
    burst = 0;
    forever begin
      @(negedge clk);
      if (no_stall) begin
        out_ready <= 1;
      end else if (burst > 0) begin
        burst--;
        if (burst == 0) out_ready <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        out_ready <= 0;
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  initial begin
    idle_cycles = 0;
    timed_out = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  stim_t directed[$];

  initial begin
    stim_t s;
    rst = 1;
    cfg_we = 0; cfg_index = CFG_COUNT; cfg_data = 0;
    in_valid = 0; opcode = OP_WRITE; entry_index = 0;
    center_x = 0; center_y = 0; radius = 0; bottom_z = 0; top_z = 0;
    point_x = 0; point_y = 0; point_z = 0;
    mismatches = 0; no_stall = 0;
    m_count = 0; m_height = 3277; m_hit = 7864; m_warn = 19661; m_lift = 9830;
    m_hitcost = 128000000; m_wgain = 200000; m_lgain = 1000;
    foreach (written[i]) written[i] = 0;
    foreach (table_q[i]) table_q[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty table gives zero, then hits, band, extremes
    s = query_item(0, 0, 0); s.chk = 1; s.want = '{cost: 40'd0, sat: 1'b0};
    directed.insert(directed.size(), s);
    s = query_item(-8388608, 8388607, -8388608); s.chk = 1; s.want = '0;
    directed.insert(directed.size(), s);
    foreach (table_q[i])
      directed.insert(directed.size(), cyl_item(i, 0, 0, 65536, -65536, 65536));
    directed.insert(directed.size(), cyl_item(15, -8388608, 8388607, 8388607, -8388608, 8388607));
    foreach (directed[i]) send(directed[i]);
    directed.delete();

    drain();
    write_reg(CFG_COUNT, 1);
    s = query_item(0, 0, 0); s.chk = 1; s.want = '{cost: 40'd128000000, sat: 1'b0};
    directed.insert(directed.size(), s);
    directed.insert(directed.size(), query_item(65536 + 10000, 0, 0));
    directed.insert(directed.size(), query_item(0, 65536 + 20000, 65536 + 3000));
    directed.insert(directed.size(), query_item(0, 0, 65536 + 3278));
    directed.insert(directed.size(), query_item(0, 0, -65536 - 3277));
    directed.insert(directed.size(), query_item(8388607, -8388608, 8388607));
    foreach (directed[i]) send(directed[i]);
    directed.delete();

    // sixteen active entries, fifteen of them hit at maximum hit cost, then wide warning and lift bands
    drain();
    write_reg(CFG_COUNT, 31);
    write_reg(CFG_HITCOST, 32'hFFFFFFFF);
    send(query_item(0, 0, 0));
    send(query_item(0, 0, 0));
    drain();
    write_reg(CFG_HEIGHT, 32'hFFFFF);
    write_reg(CFG_HIT, 0);
    write_reg(CFG_WARN, 32'hFFFFF);
    write_reg(CFG_LIFT, 32'hFFFFF);
    write_reg(CFG_WGAIN, 32'hFFFFF);
    write_reg(CFG_LGAIN, 32'hFFFF);
    send(query_item(200000, 0, -400000));
    send(query_item(-8388608, -8388608, -8388608));

    // random phases with varied settings
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(CFG_COUNT, (ph % 4 == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16));
      write_reg(CFG_HEIGHT, (ph == 3) ? 0 : $urandom_range(0, 60000));
      write_reg(CFG_HIT, (ph == 5) ? 32'hFFFFF : $urandom_range(0, 40000));
      write_reg(CFG_WARN, $urandom_range(0, 200000));
      write_reg(CFG_LIFT, $urandom_range(0, 40000));
      write_reg(CFG_HITCOST, (ph == 7) ? 0 : $urandom);
      write_reg(CFG_WGAIN, $urandom_range(0, 20'hFFFFF));
      write_reg(CFG_LGAIN, $urandom_range(0, 16'hFFFF));
      if (ph == 11) no_stall = 1;
      for (int k = 0; k < 52; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          s = rand_cyl($urandom_range(0, 15));
          send(s);
        end else begin
          // only query entries that have been loaded
          s = rand_query();
          send(s);
        end
        if (k == 20 && ph == 2) while (pending_costs.size() != 0) @(negedge clk);
      end
    end

    while (pending_costs.size() != 0) @(negedge clk);
    repeat (700) @(negedge clk);
    if (mismatches == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== cylinder_obstacle_cost.f =====
+incdir+rtl
rtl/coc_pkg.sv
rtl/coc_ram.sv
rtl/coc_front.sv
rtl/coc_back.sv
rtl/cylinder_obstacle_cost.sv
dv/tb_top.sv
